// ===== src/hbs_pkg.sv =====
`default_nettype none

package hbs_pkg;

  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 256;
  localparam int StoreDepth = MaxWidth * MaxHeight;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int CfgW       = 9;
  localparam int DimW       = CfgW;
  localparam int PosW       = 17;
  localparam int FracW      = 16;
  localparam int PixW       = 8;
  localparam int HeightW    = 17;
  localparam int PaddrW     = 3;

  localparam logic [PosW-1:0] OneQ16 = 17'h10000;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // sample beat leaving address generation, aligned with the store read
  typedef struct packed {
    logic             valid;
    logic [FracW-1:0] fx;
    logic [FracW-1:0] fy;
  } smp_ctl_t;

endpackage

`default_nettype wire

// ===== src/hbs_ram.sv =====
`default_nettype none

module hbs_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/hbs_addr.sv =====
`default_nettype none

module hbs_addr import hbs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic             mode_i,
  input  wire logic [AddrW-1:0] pixel_index_i,
  input  wire logic [PixW-1:0]  pixel_value_i,
  input  wire logic [PosW-1:0]  pos_x_i,
  input  wire logic [PosW-1:0]  pos_y_i,
  input  wire logic [CfgW-1:0]  cfg_width_i,
  input  wire logic [CfgW-1:0]  cfg_height_i,
  output logic                  we_o,
  output logic      [AddrW-1:0] waddr_o,
  output logic      [PixW-1:0]  wdata_o,
  output logic      [AddrW-1:0] a00_o,
  output logic      [AddrW-1:0] a01_o,
  output logic      [AddrW-1:0] a10_o,
  output logic      [AddrW-1:0] a11_o,
  output smp_ctl_t              ctl_o
);

  localparam int PxW = PosW + ColW;
  localparam int PyW = PosW + RowW;

  logic [DimW-1:0] w_c, h_c;
  logic [ColW-1:0] wm1_c;
  logic [RowW-1:0] hm1_c;
  logic [PosW-1:0] px_sat, py_sat;

  // stage A
  logic             va_q, mode_a_q;
  logic [AddrW-1:0] idx_a_q;
  logic [PixW-1:0]  val_a_q;
  logic [PxW-1:0]   px_a_q;
  logic [PyW-1:0]   py_a_q;
  logic [ColW-1:0]  wm1_a_q;
  logic [RowW-1:0]  hm1_a_q;
  logic [DimW-1:0]  w_a_q;

  // stage B
  logic             vb_q, mode_b_q;
  logic [AddrW-1:0] idx_b_q;
  logic [PixW-1:0]  val_b_q;
  logic [ColW-1:0]  xl_b_q, xu_b_q;
  logic [AddrW-1:0] rowl_b_q, rowu_b_q;
  logic [FracW-1:0] fx_b_q, fy_b_q;

  logic [ColW-1:0] xl_a, xu_a;
  logic [RowW-1:0] yl_a, yu_a;

  always_comb begin
    priority if (cfg_width_i == '0) begin
      w_c = DimW'(1);
    end else if (cfg_width_i > DimW'(MaxWidth)) begin
      w_c = DimW'(MaxWidth);
    end else begin
      w_c = cfg_width_i;
    end
    priority if (cfg_height_i == '0) begin
      h_c = DimW'(1);
    end else if (cfg_height_i > DimW'(MaxHeight)) begin
      h_c = DimW'(MaxHeight);
    end else begin
      h_c = cfg_height_i;
    end
    wm1_c  = ColW'(w_c - DimW'(1));
    hm1_c  = RowW'(h_c - DimW'(1));
    px_sat = (pos_x_i > OneQ16) ? OneQ16 : pos_x_i;
    py_sat = (pos_y_i > OneQ16) ? OneQ16 : pos_y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_a_q <= mode_i;
      idx_a_q  <= pixel_index_i;
      val_a_q  <= pixel_value_i;
      px_a_q   <= PxW'(px_sat) * PxW'(wm1_c);
      py_a_q   <= PyW'(py_sat) * PyW'(hm1_c);
      wm1_a_q  <= wm1_c;
      hm1_a_q  <= hm1_c;
      w_a_q    <= w_c;
    end
  end

  always_comb begin
    xl_a = px_a_q[FracW +: ColW];
    yl_a = py_a_q[FracW +: RowW];
    xu_a = (xl_a == wm1_a_q) ? xl_a : ColW'(xl_a + ColW'(1));
    yu_a = (yl_a == hm1_a_q) ? yl_a : RowW'(yl_a + RowW'(1));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_b_q <= mode_a_q;
      idx_b_q  <= idx_a_q;
      val_b_q  <= val_a_q;
      xl_b_q   <= xl_a;
      xu_b_q   <= xu_a;
      rowl_b_q <= AddrW'(AddrW'(yl_a) * AddrW'(w_a_q));
      rowu_b_q <= AddrW'(AddrW'(yu_a) * AddrW'(w_a_q));
      fx_b_q   <= px_a_q[FracW-1:0];
      fy_b_q   <= py_a_q[FracW-1:0];
    end
  end

  // stage C: loads write here, in order with the sample reads
  assign we_o    = en_i && vb_q && (mode_b_q == MODE_LOAD);
  assign waddr_o = idx_b_q;
  assign wdata_o = val_b_q;
  assign a00_o   = AddrW'(rowl_b_q + AddrW'(xl_b_q));
  assign a01_o   = AddrW'(rowl_b_q + AddrW'(xu_b_q));
  assign a10_o   = AddrW'(rowu_b_q + AddrW'(xl_b_q));
  assign a11_o   = AddrW'(rowu_b_q + AddrW'(xu_b_q));

  assign ctl_o.valid = vb_q && (mode_b_q == MODE_SAMPLE);
  assign ctl_o.fx    = fx_b_q;
  assign ctl_o.fy    = fy_b_q;

endmodule

`default_nettype wire

// ===== src/hbs_blend.sv =====
`default_nettype none

module hbs_blend import hbs_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  smp_ctl_t             ctl_i,
  input  wire logic [PixW-1:0] d00_i,
  input  wire logic [PixW-1:0] d01_i,
  input  wire logic [PixW-1:0] d10_i,
  input  wire logic [PixW-1:0] d11_i,
  output logic                 valid_o,
  output logic  [HeightW-1:0]  height_o
);

  localparam int TW = PixW + PosW;
  localparam int SW = TW + PosW;
  localparam int MW = SW - FracW;
  localparam int RecipW = 17;
  localparam int PW = MW + RecipW;
  localparam logic [SW-1:0]     RoundBias = SW'(255 * 32768);
  localparam logic [RecipW-1:0] Recip255  = RecipW'(65793);  // 2^24 / 255, truncated

  logic             vd_q, ve_q, vf_q, vg_q, vo_q;
  logic [FracW-1:0] fx_d_q, fy_d_q, fy_e_q;
  logic [TW-1:0]    t0_e_q, t1_e_q;
  logic [SW-1:0]    sum_f_q;
  logic [MW-1:0]    m_g_q;
  logic [HeightW-1:0] q0_g_q, height_q;

  logic [PosW-1:0] gx_d, gy_e;
  logic [MW-1:0]   m_f;
  logic [PW-1:0]   prod_f;
  logic [MW-1:0]   rem_g;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      vd_q <= ctl_i.valid;
      ve_q <= vd_q;
      vf_q <= ve_q;
      vg_q <= vf_q;
      vo_q <= vg_q;
    end
  end

  always_comb begin
    gx_d   = OneQ16 - PosW'(fx_d_q);
    gy_e   = OneQ16 - PosW'(fy_e_q);
    m_f    = MW'((sum_f_q + RoundBias) >> FracW);
    prod_f = PW'(m_f) * PW'(Recip255);
    rem_g  = MW'(m_g_q - MW'({q0_g_q, 8'h00}) + MW'(q0_g_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fx_d_q   <= ctl_i.fx;
      fy_d_q   <= ctl_i.fy;
      // horizontal blend on the two rows
      t0_e_q   <= TW'(d00_i) * TW'(gx_d) + TW'(d01_i) * TW'(fx_d_q);
      t1_e_q   <= TW'(d10_i) * TW'(gx_d) + TW'(d11_i) * TW'(fx_d_q);
      fy_e_q   <= fy_d_q;
      sum_f_q  <= SW'(t0_e_q) * SW'(gy_e) + SW'(t1_e_q) * SW'(fy_e_q);
      m_g_q    <= m_f;
      q0_g_q   <= HeightW'(prod_f >> 24);
      // reciprocal estimate is low by at most one
      height_q <= (rem_g >= MW'(255)) ? HeightW'(q0_g_q + HeightW'(1)) : q0_g_q;
    end
  end

  assign valid_o  = vo_q;
  assign height_o = height_q;

endmodule

`default_nettype wire

// ===== src/heightmap_bilinear_sampler_core.sv =====
`default_nettype none
// Bilinear heightmap sampler.
// Input channel (valid_i/stall_o): mode_i=0 writes pixel_value_i at pixel_index_i
// (row * width + column); mode_i=1 samples at Q1.16 pos_x_i/pos_y_i.
// Output channel (valid_o/stall_i): one height_o beat (Q1.16) per sample, none
// per write. Beats leave in input order.
// Throughput: one item per cycle while no stall holds the pipeline. A sample
// result passes address math, store read, two blend multiply stages and
// divide-by-255 via reciprocal and correction before it shows on valid_o.
// The store is four copies of the 64K x 8 map, one per neighbor, so all four
// neighbors are read in the same cycle; writes go to all copies.
// A stall from the receiver freezes the whole pipeline, and stall_o follows it
// while a result waits. Nothing is lost or repeated.
// Reset clears the pipeline valids and sets width and height to 256; the map
// contents are undefined until written, and need no clearing pass.
// Width/height (APB, offsets 0x0 and 0x4) may change only while the block is idle.

module heightmap_bilinear_sampler_core import hbs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    stall_o,
  input  wire logic               mode_i,
  input  wire logic [AddrW-1:0]   pixel_index_i,
  input  wire logic [PixW-1:0]    pixel_value_i,
  input  wire logic [PosW-1:0]    pos_x_i,
  input  wire logic [PosW-1:0]    pos_y_i,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output logic      [HeightW-1:0] height_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PaddrW-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  logic [CfgW-1:0] width_q, height_cfg_q;
  logic            en;
  logic            we;
  logic [AddrW-1:0] waddr;
  logic [PixW-1:0]  wdata;
  logic [AddrW-1:0] addr [4];
  logic [PixW-1:0]  rdata [4];
  smp_ctl_t         ctl;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= CfgW'(256);
      height_cfg_q <= CfgW'(256);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_WIDTH:  width_q      <= pwdata[CfgW-1:0];
        REG_HEIGHT: height_cfg_q <= pwdata[CfgW-1:0];
        default:    width_q      <= width_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_cfg_q);
      default:    prdata = '0;
    endcase
  end

  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  hbs_addr u_addr (
    .clk_i,
    .rst_ni,
    .en_i          (en),
    .valid_i,
    .mode_i,
    .pixel_index_i,
    .pixel_value_i,
    .pos_x_i,
    .pos_y_i,
    .cfg_width_i   (width_q),
    .cfg_height_i  (height_cfg_q),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .a00_o         (addr[0]),
    .a01_o         (addr[1]),
    .a10_o         (addr[2]),
    .a11_o         (addr[3]),
    .ctl_o         (ctl)
  );

  for (genvar g = 0; g < 4; g++) begin : g_bank
    hbs_ram #(
      .Width (PixW),
      .Depth (StoreDepth)
    ) u_ram (
      .clk_i,
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .re_i    (en),
      .raddr_i (addr[g]),
      .rdata_o (rdata[g])
    );
  end

  hbs_blend u_blend (
    .clk_i,
    .rst_ni,
    .en_i     (en),
    .ctl_i    (ctl),
    .d00_i    (rdata[0]),
    .d01_i    (rdata[1]),
    .d10_i    (rdata[2]),
    .d11_i    (rdata[3]),
    .valid_o,
    .height_o
  );

endmodule

`default_nettype wire

// ===== src/hbs_checker.sv =====
`default_nettype none

module hbs_checker import hbs_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               stall_o,
  input wire logic               valid_o,
  input wire logic               stall_i,
  input wire logic [HeightW-1:0] height_o
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("output beat dropped under stall");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(height_o))
    else $error("output beat changed under stall");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> height_o <= HeightW'(65536))
    else $error("height above 1.0");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input stalled without a waiting result");

endmodule

bind heightmap_bilinear_sampler_core hbs_checker u_hbs_checker (
  .clk_i,
  .rst_ni,
  .stall_o,
  .valid_o,
  .stall_i,
  .height_o
);

`default_nettype wire

// ===== dv/heightmap_bilinear_sampler_core_test.sv =====
`default_nettype none

module heightmap_bilinear_sampler_core_test;
  import hbs_pkg::*;

  localparam int IdleLimit = 5000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               valid_i = 1'b0;
  logic               stall_o;
  logic               mode_i = MODE_LOAD;
  logic [AddrW-1:0]   pixel_index_i = '0;
  logic [PixW-1:0]    pixel_value_i = '0;
  logic [PosW-1:0]    pos_x_i = '0;
  logic [PosW-1:0]    pos_y_i = '0;
  logic               valid_o;
  logic               stall_i = 1'b0;
  logic [HeightW-1:0] height_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PaddrW-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  heightmap_bilinear_sampler_core DUT (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // shadow of the block: map contents, which entries were loaded, dimensions
  logic [PixW-1:0]    map_shadow [StoreDepth];
  bit                 loaded [StoreDepth];
  logic [DimW-1:0]    width_reg = 9'd256;
  logic [DimW-1:0]    height_reg = 9'd256;
  logic [HeightW-1:0] height_q [$];
  int                 fail_cnt = 0;
  int                 items_sent = 0;
  int                 stall_left = 0;
  int                 idle_cycles = 0;
  bit                 calm = 1'b0;

  function automatic int eff_dim(logic [DimW-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void split_axis(input logic [PosW-1:0] pos, input int dim,
                                     output int lo, output int hi, output int frac);
    longint p;
    longint prod;
    p = (pos > OneQ16) ? 65536 : pos;
    prod = p * (dim - 1);
    lo = int'(prod >> 16);
    hi = (lo + 1 > dim - 1) ? dim - 1 : lo + 1;
    frac = int'(prod & 64'hFFFF);
  endfunction

  function automatic logic [HeightW-1:0] blend_height(logic [PosW-1:0] px, logic [PosW-1:0] py);
    int w, h, xl, xu, yl, yu, fx, fy;
    longint unsigned gx, gy, sum;
    w = eff_dim(width_reg, MaxWidth);
    h = eff_dim(height_reg, MaxHeight);
    split_axis(px, w, xl, xu, fx);
    split_axis(py, h, yl, yu, fy);
    gx = 65536 - fx;
    gy = 65536 - fy;
    sum = map_shadow[yl*w+xl] * gx * gy + map_shadow[yl*w+xu] * fx * gy
        + map_shadow[yu*w+xl] * gx * fy + map_shadow[yu*w+xu] * fx * fy;
    return HeightW'((sum + 64'd255 * 32768) / (64'd255 * 65536));
  endfunction

  function automatic int rand_gap();
    int r;
    if (calm) return 0;
    r = $urandom % 16;
    if (r < 9) return 0;
    if (r < 15) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // output side: check every accepted beat, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (height_q.size() == 0) begin
        $error("height: unexpected beat, got %0d", height_o);
        fail_cnt++;
      end else begin
        logic [HeightW-1:0] exp_h;
        exp_h = height_q.pop_front();
        if (height_o !== exp_h) begin
          $error("height: expected %0d, got %0d", exp_h, height_o);
          fail_cnt++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_i <= 1'b1;
      stall_left--;
    end else begin
      stall_i <= 1'b0;
      if (!calm && ($urandom % 8 == 0)) stall_left = rand_gap();
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_beat(logic mode, logic [AddrW-1:0] idx, logic [PixW-1:0] val,
                           logic [PosW-1:0] px, logic [PosW-1:0] py);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    mode_i <= mode;
    pixel_index_i <= idx;
    pixel_value_i <= val;
    pos_x_i <= px;
    pos_y_i <= py;
    do @(posedge clk_i); while (stall_o);
    if (mode == MODE_LOAD) begin
      map_shadow[idx] = val;
      loaded[idx] = 1'b1;
    end else begin
      height_q.push_back(blend_height(px, py));
    end
    items_sent++;
  endtask

  task automatic load_pixel(logic [AddrW-1:0] idx, logic [PixW-1:0] val);
    send_beat(MODE_LOAD, idx, val, PosW'($urandom), PosW'($urandom));
  endtask

  // loads any neighbor not yet written, then samples
  task automatic sample_at(logic [PosW-1:0] px, logic [PosW-1:0] py);
    int w, h, xl, xu, yl, yu, fx, fy;
    int nb [4];
    w = eff_dim(width_reg, MaxWidth);
    h = eff_dim(height_reg, MaxHeight);
    split_axis(px, w, xl, xu, fx);
    split_axis(py, h, yl, yu, fy);
    nb = '{yl*w+xl, yl*w+xu, yu*w+xl, yu*w+xu};
    foreach (nb[i])
      if (!loaded[nb[i]]) load_pixel(AddrW'(nb[i]), PixW'($urandom));
    send_beat(MODE_SAMPLE, AddrW'($urandom), PixW'($urandom), px, py);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (height_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic apb_write(logic reg_sel, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {reg_sel, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_WIDTH) width_reg = data[DimW-1:0];
    else height_reg = data[DimW-1:0];
    @(posedge clk_i);
  endtask

  task automatic set_dims(logic [DimW-1:0] w, logic [DimW-1:0] h);
    drain();
    apb_write(REG_WIDTH, {23'h0, w});
    apb_write(REG_HEIGHT, {23'h0, h});
  endtask

  function automatic logic [PosW-1:0] rand_pos();
    int r;
    r = $urandom % 10;
    if (r == 0) return '0;
    if (r == 1) return OneQ16;
    if (r == 2) return PosW'($urandom_range(65537, 131071));
    return PosW'($urandom_range(0, 65536));
  endfunction

  // reset dimensions: corners, extreme byte values, positions past one
  task automatic test_reset_dims();
    load_pixel(16'd0, 8'hFF);
    load_pixel(16'hFFFF, 8'h00);
    load_pixel(16'd1, 8'h00);
    load_pixel(16'd256, 8'hFF);
    sample_at(17'd0, 17'd0);
    sample_at(OneQ16, OneQ16);
    sample_at(17'h1FFFF, 17'h1FFFF);
    sample_at(17'h08000, 17'h00000);
    sample_at(17'h0FFFF, 17'h00100);
    sample_at(17'h10001, 17'h0ABCD);
  endtask

  // zero, one, two and oversized dimensions
  task automatic test_dim_extremes();
    logic [DimW-1:0] dims [6][2];
    dims = '{'{9'd1, 9'd1}, '{9'd0, 9'd0}, '{9'd2, 9'd2}, '{9'd511, 9'd300},
             '{9'd256, 9'd1}, '{9'd1, 9'd256}};
    foreach (dims[i]) begin
      set_dims(dims[i][0], dims[i][1]);
      sample_at(17'd0, 17'd0);
      sample_at(OneQ16, 17'h1FFFF);
      sample_at(17'h07FFF, OneQ16);
    end
  endtask

  task automatic test_random();
    logic [DimW-1:0] w, h;
    int r;
    while (items_sent < 950) begin
      r = $urandom % 8;
      if (r < 5) begin
        w = DimW'($urandom_range(1, 16));
        h = DimW'($urandom_range(1, 16));
      end else begin
        w = DimW'($urandom);
        h = DimW'($urandom);
      end
      set_dims(w, h);
      calm = ($urandom % 4 == 0);
      repeat (60) begin
        if (items_sent >= 950) break;
        if ($urandom % 10 < 7) sample_at(rand_pos(), rand_pos());
        else load_pixel(AddrW'($urandom), PixW'($urandom));
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_dims();
    test_dim_extremes();
    test_random();
    drain();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
